// ===== rtl/core/ssts_pkg.sv =====
// ----------------------------------------------------------------------------
// ssts_pkg
// Shared types, constants and helpers for the seven-segment time serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssts_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_TIME   = 2'd1;
   localparam logic [1:0] OP_BRIGHT = 2'd2;

   localparam logic [7:0] CMD_DATA_AUTO    = 8'h40;
   localparam logic [7:0] CMD_ADDR_FIRST   = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h88;
   localparam logic [7:0] BRIGHT_MASK      = 8'h07;
   localparam logic [7:0] COLON_BIT        = 8'h80;
   localparam logic [7:0] LSB_MASK         = 8'h01;
   localparam logic [6:0] MAX_TWO_DIGIT    = 7'd99;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_TIME   = 2'd1,
      KIND_BRIGHT = 2'd2
   } item_kind_type;

   typedef enum logic [4:0] {
      PH_IDLE         = 5'd0,
      PH_START_CLK_HI = 5'd1,
      PH_START_DAT_HI = 5'd2,
      PH_START_DAT_LO = 5'd3,
      PH_START_CLK_LO = 5'd4,
      PH_BIT_CLK_LO   = 5'd5,
      PH_BIT_DAT      = 5'd6,
      PH_BIT_CLK_HI   = 5'd7,
      PH_ACK_CLK_LO   = 5'd8,
      PH_ACK_RELEASE  = 5'd9,
      PH_ACK_CLK_HI   = 5'd10,
      PH_ACK_CLK_LO2  = 5'd11,
      PH_ACK_DRIVE    = 5'd12,
      PH_STOP_CLK_LO  = 5'd13,
      PH_STOP_DAT_LO  = 5'd14,
      PH_STOP_CLK_HI  = 5'd15,
      PH_STOP_DAT_HI  = 5'd16
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] minutes;
      logic [6:0] seconds;
      logic       colon;
   } req_payload_type;

   typedef struct packed {
      logic clk_line;
      logic data_line;
      logic data_drive;
      logic busy_res;
      logic accepted;
   } rsp_payload_type;

   typedef struct packed {
      item_kind_type                kind;
      logic [DIGIT_COUNT-1:0][7:0]  seg;
   } queue_item_type;

   // Queue status seen by the front and back halves
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'h3F;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5B;
         4'd3:    code = 8'h4F;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6D;
         4'd6:    code = 8'h7D;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7F;
         4'd9:    code = 8'h6F;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/seven_segment_time_serializer_top.sv =====
// ----------------------------------------------------------------------------
// seven_segment_time_serializer_top
// A request's response is registered when its queue item is popped.
// Throughput: one item per cycle when rsp_ready allows; single-step sequencer.
// A two-entry queue decouples request intake from the sequencer.
// Reset (synchronous): idle, pins clock high / data high / driven, brightness 3.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_time_serializer_top (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  ssts_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output ssts_pkg::rsp_payload_type rsp_data,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [2:0]                csr_data
);

   ssts_pkg::queue_status_type q_status;
   ssts_pkg::queue_item_type   push_item;
   ssts_pkg::queue_item_type   pop_item;
   logic                       q_push;
   logic                       q_pop;

   assign csr_ready = 1'b1;

   ssts_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   ssts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   ssts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid & csr_ready),
      .csr_wdata (csr_data),
      .q_status  (q_status),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ssts_front.sv =====
// ----------------------------------------------------------------------------
// ssts_front
// Accepts requests, classifies them and precomputes digit segment codes.
// ----------------------------------------------------------------------------
`default_nettype none

module ssts_front (
   input  wire                        req_valid,
   output logic                       req_ready,
   input  ssts_pkg::req_payload_type  req_data,
   input  ssts_pkg::queue_status_type q_status,
   output logic                       q_push,
   output ssts_pkg::queue_item_type   q_item
);

   // Tens digit of a value up to 99: reciprocal multiply, exact for any 7-bit input
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] prod;
      prod = 15'(v) * 15'd205;
      return prod[14:11];
   endfunction

   function automatic logic [3:0] mod10(input logic [6:0] v, input logic [3:0] q);
      logic [6:0] r;
      r = v - 7'(q) * 7'd10;
      return r[3:0];
   endfunction

   logic [6:0] min_sat;
   logic [6:0] sec_sat;
   logic [3:0] min_tens;
   logic [3:0] sec_tens;
   logic [7:0] codes [4];

   assign req_ready = ~q_status.full;
   assign q_push    = req_valid & req_ready;

   always_comb begin
      min_sat  = (req_data.minutes > ssts_pkg::MAX_TWO_DIGIT) ?
                 ssts_pkg::MAX_TWO_DIGIT : req_data.minutes;
      sec_sat  = (req_data.seconds > ssts_pkg::MAX_TWO_DIGIT) ?
                 ssts_pkg::MAX_TWO_DIGIT : req_data.seconds;
      min_tens = div10(min_sat);
      sec_tens = div10(sec_sat);
      codes[0] = ssts_pkg::seg_code(min_tens);
      codes[1] = ssts_pkg::seg_code(mod10(min_sat, min_tens));
      codes[2] = ssts_pkg::seg_code(sec_tens);
      codes[3] = ssts_pkg::seg_code(mod10(sec_sat, sec_tens));
      if (req_data.colon) begin
         codes[1] = codes[1] | ssts_pkg::COLON_BIT;
      end
   end

   always_comb begin
      unique case (req_data.opcode)
         ssts_pkg::OP_TIME:   q_item.kind = ssts_pkg::KIND_TIME;
         ssts_pkg::OP_BRIGHT: q_item.kind = ssts_pkg::KIND_BRIGHT;
         default:             q_item.kind = ssts_pkg::KIND_TICK;
      endcase
      for (int k = 0; k < ssts_pkg::DIGIT_COUNT; k++) begin
         // positions past the fourth are blank
         if (k < 4) begin
            q_item.seg[k] = codes[k[1:0]];
         end else begin
            q_item.seg[k] = 8'h00;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ssts_queue.sv =====
// ----------------------------------------------------------------------------
// ssts_queue
// Short register queue between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module ssts_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  ssts_pkg::queue_item_type   push_item,
   input  wire                        pop,
   output ssts_pkg::queue_item_type   pop_item,
   output ssts_pkg::queue_status_type status
);

   ssts_pkg::queue_item_type                 entries_ff [ssts_pkg::QUEUE_DEPTH];
   logic [ssts_pkg::QUEUE_PTR_W-1:0]         wr_ptr_ff;
   logic [ssts_pkg::QUEUE_PTR_W-1:0]         wr_ptr_in;
   logic [ssts_pkg::QUEUE_PTR_W-1:0]         rd_ptr_ff;
   logic [ssts_pkg::QUEUE_PTR_W-1:0]         rd_ptr_in;
   logic [ssts_pkg::QUEUE_CNT_W-1:0]         count_ff;
   logic [ssts_pkg::QUEUE_CNT_W-1:0]         count_in;

   assign status.full  = (count_ff == ssts_pkg::QUEUE_CNT_W'(ssts_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ssts_back.sv =====
// ----------------------------------------------------------------------------
// ssts_back
// Link sequencer: one pin action per tick, result register toward rsp side.
// ----------------------------------------------------------------------------
`default_nettype none

module ssts_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire  [2:0]                 csr_wdata,
   input  ssts_pkg::queue_status_type q_status,
   input  ssts_pkg::queue_item_type   q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output ssts_pkg::rsp_payload_type  rsp_data
);

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [3:0] LAST_DIGIT    = 4'(ssts_pkg::DIGIT_COUNT + 1);

   ssts_pkg::phase_type                   phase_ff, phase_in;
   logic [2:0]                            fbi_ff, fbi_in;
   logic [3:0]                            bit_ff, bit_in;
   logic [7:0]                            shift_ff, shift_in;
   logic [ssts_pkg::DIGIT_COUNT-1:0][7:0] seg_ff, seg_in;
   logic                                  kind_ff, kind_in;
   logic                                  clk_ff, clk_in;
   logic                                  dat_ff, dat_in;
   logic                                  drv_ff, drv_in;
   logic [2:0]                            bright_ff, bright_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   ssts_pkg::rsp_payload_type             rsp_data_ff, rsp_data_in;
   logic                                  taken;
   logic [3:0]                            bit_next;
   logic [2:0]                            done_idx;

   assign q_pop     = ~q_status.empty & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign bright_in = csr_we ? csr_wdata : bright_ff;
   assign bit_next  = bit_ff + 4'd1;
   assign done_idx  = fbi_ff - 3'd1;

   always_comb begin
      phase_in     = phase_ff;
      fbi_in       = fbi_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      seg_in       = seg_ff;
      kind_in      = kind_ff;
      clk_in       = clk_ff;
      dat_in       = dat_ff;
      drv_in       = drv_ff;
      taken        = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (q_pop) begin
         if (q_item.kind == ssts_pkg::KIND_TIME || q_item.kind == ssts_pkg::KIND_BRIGHT) begin
            // requests while a transfer runs are dropped
            if (phase_ff == ssts_pkg::PH_IDLE) begin
               taken    = 1'b1;
               fbi_in   = 3'd0;
               bit_in   = 4'd0;
               phase_in = ssts_pkg::PH_START_CLK_HI;
               if (q_item.kind == ssts_pkg::KIND_TIME) begin
                  kind_in  = 1'b1;
                  seg_in   = q_item.seg;
                  shift_in = ssts_pkg::CMD_DATA_AUTO;
               end else begin
                  kind_in  = 1'b0;
                  shift_in = ssts_pkg::CMD_DISPLAY_CTRL |
                             ({5'd0, bright_ff} & ssts_pkg::BRIGHT_MASK);
               end
            end
         end else if (phase_ff != ssts_pkg::PH_IDLE) begin
            unique case (phase_ff)
               ssts_pkg::PH_START_CLK_HI: begin
                  clk_in   = 1'b1;
                  phase_in = ssts_pkg::PH_START_DAT_HI;
               end
               ssts_pkg::PH_START_DAT_HI: begin
                  dat_in   = 1'b1;
                  phase_in = ssts_pkg::PH_START_DAT_LO;
               end
               ssts_pkg::PH_START_DAT_LO: begin
                  dat_in   = 1'b0;
                  phase_in = ssts_pkg::PH_START_CLK_LO;
               end
               ssts_pkg::PH_START_CLK_LO: begin
                  clk_in   = 1'b0;
                  bit_in   = 4'd0;
                  phase_in = ssts_pkg::PH_BIT_CLK_LO;
               end
               ssts_pkg::PH_BIT_CLK_LO: begin
                  clk_in   = 1'b0;
                  phase_in = ssts_pkg::PH_BIT_DAT;
               end
               ssts_pkg::PH_BIT_DAT: begin
                  dat_in   = |(shift_ff & ssts_pkg::LSB_MASK);
                  phase_in = ssts_pkg::PH_BIT_CLK_HI;
               end
               ssts_pkg::PH_BIT_CLK_HI: begin
                  clk_in   = 1'b1;
                  shift_in = shift_ff >> 1;
                  bit_in   = bit_next;
                  phase_in = (bit_next >= BITS_PER_BYTE) ? ssts_pkg::PH_ACK_CLK_LO
                                                         : ssts_pkg::PH_BIT_CLK_LO;
               end
               ssts_pkg::PH_ACK_CLK_LO: begin
                  clk_in   = 1'b0;
                  phase_in = ssts_pkg::PH_ACK_RELEASE;
               end
               ssts_pkg::PH_ACK_RELEASE: begin
                  drv_in   = 1'b0;
                  dat_in   = 1'b0;
                  phase_in = ssts_pkg::PH_ACK_CLK_HI;
               end
               ssts_pkg::PH_ACK_CLK_HI: begin
                  clk_in   = 1'b1;
                  phase_in = ssts_pkg::PH_ACK_CLK_LO2;
               end
               ssts_pkg::PH_ACK_CLK_LO2: begin
                  clk_in   = 1'b0;
                  phase_in = ssts_pkg::PH_ACK_DRIVE;
               end
               ssts_pkg::PH_ACK_DRIVE: begin
                  drv_in = 1'b1;
                  fbi_in = fbi_ff + 3'd1;
                  // after the address byte, stream the digit codes in order
                  if (kind_ff && fbi_ff >= 3'd1 && {1'b0, fbi_ff} < LAST_DIGIT) begin
                     shift_in = 8'h00;
                     for (int j = 0; j < ssts_pkg::DIGIT_COUNT; j++) begin
                        if (done_idx == 3'(j)) begin
                           shift_in = seg_ff[j];
                        end
                     end
                     bit_in   = 4'd0;
                     phase_in = ssts_pkg::PH_BIT_CLK_LO;
                  end else begin
                     phase_in = ssts_pkg::PH_STOP_CLK_LO;
                  end
               end
               ssts_pkg::PH_STOP_CLK_LO: begin
                  clk_in   = 1'b0;
                  phase_in = ssts_pkg::PH_STOP_DAT_LO;
               end
               ssts_pkg::PH_STOP_DAT_LO: begin
                  dat_in   = 1'b0;
                  phase_in = ssts_pkg::PH_STOP_CLK_HI;
               end
               ssts_pkg::PH_STOP_CLK_HI: begin
                  clk_in   = 1'b1;
                  phase_in = ssts_pkg::PH_STOP_DAT_HI;
               end
               ssts_pkg::PH_STOP_DAT_HI: begin
                  dat_in = 1'b1;
                  // time display: command frame done, go on to the address frame
                  if (kind_ff && fbi_ff == 3'd1) begin
                     shift_in = ssts_pkg::CMD_ADDR_FIRST;
                     phase_in = ssts_pkg::PH_START_CLK_HI;
                  end else begin
                     phase_in = ssts_pkg::PH_IDLE;
                  end
               end
               default: begin
                  phase_in = ssts_pkg::PH_IDLE;
               end
            endcase
         end

         rsp_valid_in           = 1'b1;
         rsp_data_in.clk_line   = clk_in;
         rsp_data_in.data_line  = dat_in;
         rsp_data_in.data_drive = drv_in;
         rsp_data_in.busy_res   = (phase_in != ssts_pkg::PH_IDLE);
         rsp_data_in.accepted   = taken;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ssts_pkg::PH_IDLE;
         fbi_ff       <= 3'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'h00;
         seg_ff       <= '0;
         kind_ff      <= 1'b0;
         clk_ff       <= 1'b1;
         dat_ff       <= 1'b1;
         drv_ff       <= 1'b1;
         bright_ff    <= 3'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fbi_ff       <= fbi_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         seg_ff       <= seg_in;
         kind_ff      <= kind_in;
         clk_ff       <= clk_in;
         dat_ff       <= dat_in;
         drv_ff       <= drv_in;
         bright_ff    <= bright_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
